FILE: hdl/csc_pkg.sv
// Shared constants, widths and elaboration-time table functions for the converter.
`default_nettype none
package csc_pkg;

   localparam int DP_W   = 64;            // CORDIC datapath width
   localparam int AFRAC  = 24;            // fraction bits under the 32-bit binary angle
   localparam int ANG_W  = 58;            // angle accumulator width
   localparam int ANG_OUT_W = 32;
   localparam logic [63:0] INV_PI_Q64 = 64'h517CC1B727220A95;

   // Long division by shift and subtract; used only for constants.
   function automatic logic [63:0] csc_udiv(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic logic [63:0] csc_mul_high(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return prod[127:64];
   endfunction

   // atan(2^-i) / pi with AFRAC fraction bits below the binary angle
   function automatic logic [63:0] csc_rom_angle(input int i);
      logic [63:0] sum;
      logic [63:0] term;
      logic [63:0] q;
      int          sh;
      sum = '0;
      if (i == 0) begin
         return 64'd1 << (29 + AFRAC);
      end
      for (int k = 0; k < 64; k++) begin
         sh = i * (2 * k + 1);
         if (sh < 63) begin
            term = csc_udiv(64'd1 << (63 - sh), 64'(2 * k + 1));
            if (k % 2 == 1) sum = sum - term;
            else            sum = sum + term;
         end
      end
      q = csc_mul_high(sum, INV_PI_Q64);
      q = (q + (64'd1 << (31 - AFRAC))) >> (32 - AFRAC);
      return q;
   endfunction

   // 1/K^2 in Q62 for the two passes of the given length
   function automatic logic [63:0] csc_gain_inverse(input int iters);
      logic [63:0] inv;
      inv = 64'd1 << 62;
      for (int i = 0; i < iters; i++) begin
         if (2 * i < 63) begin
            inv = inv - csc_udiv(inv, (64'd1 << (2 * i)) + 64'd1);
         end
      end
      return inv;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/csc_vec_stage.sv
// One registered CORDIC vectoring micro-rotation with sideband.
`default_nettype none
module csc_vec_stage
   import csc_pkg::*;
#(
   parameter int SHIFT = 0,
   parameter logic [ANG_W-1:0] ANGLE = '0,
   parameter int SIDE_W = 1
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   output logic                         in_ready,
   input  wire logic signed [DP_W-1:0]  in_x,
   input  wire logic signed [DP_W-1:0]  in_y,
   input  wire logic signed [ANG_W-1:0] in_ang,
   input  wire logic [SIDE_W-1:0]       in_side,
   output logic                         out_valid,
   input  wire logic                    out_ready,
   output logic signed [DP_W-1:0]       out_x,
   output logic signed [DP_W-1:0]       out_y,
   output logic signed [ANG_W-1:0]      out_ang,
   output logic [SIDE_W-1:0]            out_side
);
   logic                     valid_ff;
   logic signed [DP_W-1:0]   x_ff, y_ff, x_in, y_in;
   logic signed [ANG_W-1:0]  ang_ff, ang_in;
   logic [SIDE_W-1:0]        side_ff;

   assign in_ready = ~valid_ff | out_ready;

   always_comb begin
      if (!in_y[DP_W-1]) begin
         x_in   = in_x + (in_y >>> SHIFT);
         y_in   = in_y - (in_x >>> SHIFT);
         ang_in = in_ang + ANGLE;
      end else begin
         x_in   = in_x - (in_y >>> SHIFT);
         y_in   = in_y + (in_x >>> SHIFT);
         ang_in = in_ang - ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         ang_ff  <= ang_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_ang   = ang_ff;
   assign out_side  = side_ff;
endmodule
`default_nettype wire

FILE: hdl/csc_vector.sv
// Full CORDIC vectoring pass: a chain of registered micro-rotations.
`default_nettype none
module csc_vector
   import csc_pkg::*;
#(
   parameter int ITERATIONS = 32,
   parameter int SIDE_W = 1
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   output logic                         in_ready,
   input  wire logic signed [DP_W-1:0]  in_x,
   input  wire logic signed [DP_W-1:0]  in_y,
   input  wire logic signed [ANG_W-1:0] in_ang,
   input  wire logic [SIDE_W-1:0]       in_side,
   output logic                         out_valid,
   input  wire logic                    out_ready,
   output logic signed [DP_W-1:0]       out_x,
   output logic signed [DP_W-1:0]       out_y,
   output logic signed [ANG_W-1:0]      out_ang,
   output logic [SIDE_W-1:0]            out_side
);
   logic [ITERATIONS:0]     valid_w, ready_w;
   logic signed [DP_W-1:0]  x_w   [ITERATIONS+1];
   logic signed [DP_W-1:0]  y_w   [ITERATIONS+1];
   logic signed [ANG_W-1:0] ang_w [ITERATIONS+1];
   logic [SIDE_W-1:0]       side_w[ITERATIONS+1];

   assign valid_w[0] = in_valid;
   assign in_ready   = ready_w[0];
   assign x_w[0]     = in_x;
   assign y_w[0]     = in_y;
   assign ang_w[0]   = in_ang;
   assign side_w[0]  = in_side;

   for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
      localparam logic [63:0] ROM_V = csc_rom_angle(i);
      csc_vec_stage #(
         .SHIFT (i),
         .ANGLE (ROM_V[ANG_W-1:0]),
         .SIDE_W(SIDE_W)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .in_valid (valid_w[i]),
         .in_ready (ready_w[i]),
         .in_x     (x_w[i]),
         .in_y     (y_w[i]),
         .in_ang   (ang_w[i]),
         .in_side  (side_w[i]),
         .out_valid(valid_w[i+1]),
         .out_ready(ready_w[i+1]),
         .out_x    (x_w[i+1]),
         .out_y    (y_w[i+1]),
         .out_ang  (ang_w[i+1]),
         .out_side (side_w[i+1])
      );
   end

   assign ready_w[ITERATIONS] = out_ready;
   assign out_valid = valid_w[ITERATIONS];
   assign out_x     = x_w[ITERATIONS];
   assign out_y     = y_w[ITERATIONS];
   assign out_ang   = ang_w[ITERATIONS];
   assign out_side  = side_w[ITERATIONS];
endmodule
`default_nettype wire

FILE: hdl/csc_radius_mul.sv
// Three-stage 64x64 high-half product of length and inverse gain.
`default_nettype none
module csc_radius_mul
   import csc_pkg::*;
#(
   parameter logic [63:0] INV_GAIN = 64'd0,
   parameter int SIDE_W = 1
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire logic signed [DP_W-1:0] in_mag,
   input  wire logic [SIDE_W-1:0]      in_side,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output logic [63:0]                 out_high,
   output logic [SIDE_W-1:0]           out_side
);
   localparam logic [31:0] B0 = INV_GAIN[31:0];
   localparam logic [31:0] B1 = INV_GAIN[63:32];

   logic [2:0]        valid_ff;
   logic [2:0]        rdy;
   logic [SIDE_W-1:0] side1_ff, side2_ff, side3_ff;
   logic [63:0]       mag_c;
   logic [31:0]       a1_ff;
   logic [63:0]       p00_ff, p01_ff, p00b_ff, p01b_ff, p10_ff, p11_ff;
   logic [63:0]       mid, high_in, high_ff;

   assign mag_c = in_mag[DP_W-1] ? 64'd0 : 64'(in_mag);

   assign rdy[2] = ~valid_ff[2] | out_ready;
   assign rdy[1] = ~valid_ff[1] | rdy[2];
   assign rdy[0] = ~valid_ff[0] | rdy[1];
   assign in_ready = rdy[0];

   assign mid = {32'd0, p00b_ff[63:32]} + {32'd0, p01b_ff[31:0]} + {32'd0, p10_ff[31:0]};
   assign high_in = p11_ff + {32'd0, p01b_ff[63:32]} + {32'd0, p10_ff[63:32]}
                    + {32'd0, mid[63:32]};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (rdy[0]) valid_ff[0] <= in_valid;
         if (rdy[1]) valid_ff[1] <= valid_ff[0];
         if (rdy[2]) valid_ff[2] <= valid_ff[1];
      end
      if (rdy[0] && in_valid) begin
         p00_ff   <= mag_c[31:0] * B0;
         p01_ff   <= mag_c[31:0] * B1;
         a1_ff    <= mag_c[63:32];
         side1_ff <= in_side;
      end
      if (rdy[1] && valid_ff[0]) begin
         p10_ff   <= a1_ff * B0;
         p11_ff   <= a1_ff * B1;
         p00b_ff  <= p00_ff;
         p01b_ff  <= p01_ff;
         side2_ff <= side1_ff;
      end
      if (rdy[2] && valid_ff[1]) begin
         high_ff  <= high_in;
         side3_ff <= side2_ff;
      end
   end

   assign out_valid = valid_ff[2];
   assign out_high  = high_ff;
   assign out_side  = side3_ff;
endmodule
`default_nettype wire

FILE: hdl/cartesian_to_spherical_core.sv
// Top level: pipelined CORDIC conversion of a 3D point to radius, elevation, azimuth.
//
//  channel  | direction | ports                                   | handshake
//  ---------+-----------+-----------------------------------------+----------------
//  request  | in        | req_x_coord, req_y_coord, req_z_coord   | req_valid/ready
//  response | out       | rsp_radius, rsp_elevation, rsp_azimuth  | rsp_valid/ready
//
// One item per cycle sustained while rsp_ready stays high. The pipeline holds
// one prepare stage, ITERATIONS stages per vectoring pass, three multiply
// stages and the output register. Every stage has its own valid bit and takes
// a new item when it is empty or its successor takes its content, so bubbles
// close up under a stalled output. Synchronous reset clears only valid bits.
`default_nettype none
module cartesian_to_spherical_core
   import csc_pkg::*;
#(
   parameter int ITERATIONS  = 32,
   parameter int COORD_WIDTH = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic signed [COORD_WIDTH-1:0] req_x_coord,
   input  wire logic signed [COORD_WIDTH-1:0] req_y_coord,
   input  wire logic signed [COORD_WIDTH-1:0] req_z_coord,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [COORD_WIDTH-1:0]             rsp_radius,
   output logic signed [ANG_OUT_W-1:0]        rsp_elevation,
   output logic signed [ANG_OUT_W-1:0]        rsp_azimuth
);
   localparam int GUARD = 58 - COORD_WIDTH;
   localparam logic [63:0] INV_GAIN = csc_gain_inverse(ITERATIONS);
   localparam int S1_W = DP_W + 2;      // z, xy_zero, all_zero
   localparam int S2_W = ANG_W + 2;     // azimuth, xy_zero, all_zero
   localparam int S3_W = 2 * ANG_W + 2; // elevation, azimuth, flags
   localparam logic signed [ANG_W-1:0] EL_LIM = ANG_W'(64'd1 << 30);
   localparam logic signed [ANG_W-1:0] HALF_LSB = ANG_W'(64'd1 << (AFRAC - 1));

   // ---- prepare stage: scale, fold the left half-plane by pi ----
   logic                    prep_valid_ff, prep_ready;
   logic signed [DP_W-1:0]  x_sc, y_sc, z_sc;
   logic signed [DP_W-1:0]  px_ff, py_ff, pz_ff, px_in, py_in;
   logic signed [ANG_W-1:0] paz_ff, paz_in;
   logic                    pxy_zero_ff, pall_zero_ff;

   assign x_sc = DP_W'(req_x_coord) <<< GUARD;
   assign y_sc = DP_W'(req_y_coord) <<< GUARD;
   assign z_sc = DP_W'(req_z_coord) <<< GUARD;

   always_comb begin
      if (x_sc[DP_W-1]) begin
         px_in  = -x_sc;
         py_in  = -y_sc;
         paz_in = ANG_W'(64'd1 << (31 + AFRAC));
      end else begin
         px_in  = x_sc;
         py_in  = y_sc;
         paz_in = '0;
      end
   end

   assign req_ready = ~prep_valid_ff | prep_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else if (req_ready) begin
         prep_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         px_ff        <= px_in;
         py_ff        <= py_in;
         pz_ff        <= z_sc;
         paz_ff       <= paz_in;
         pxy_zero_ff  <= (req_x_coord == '0) && (req_y_coord == '0);
         pall_zero_ff <= (req_x_coord == '0) && (req_y_coord == '0) && (req_z_coord == '0);
      end
   end

   // ---- first pass: azimuth and planar length ----
   logic                    v1_valid, v1_ready;
   logic signed [DP_W-1:0]  v1_x, v1_y;
   logic signed [ANG_W-1:0] v1_ang;
   logic [S1_W-1:0]         v1_side;

   csc_vector #(.ITERATIONS(ITERATIONS), .SIDE_W(S1_W)) u_pass_az (
      .clock    (clock),
      .reset    (reset),
      .in_valid (prep_valid_ff),
      .in_ready (prep_ready),
      .in_x     (px_ff),
      .in_y     (py_ff),
      .in_ang   (paz_ff),
      .in_side  ({pz_ff, pxy_zero_ff, pall_zero_ff}),
      .out_valid(v1_valid),
      .out_ready(v1_ready),
      .out_x    (v1_x),
      .out_y    (v1_y),
      .out_ang  (v1_ang),
      .out_side (v1_side)
   );

   // ---- second pass: elevation and full length ----
   logic                    v2_valid, v2_ready;
   logic signed [DP_W-1:0]  v2_x, v2_y;
   logic signed [ANG_W-1:0] v2_ang;
   logic [S2_W-1:0]         v2_side;

   csc_vector #(.ITERATIONS(ITERATIONS), .SIDE_W(S2_W)) u_pass_el (
      .clock    (clock),
      .reset    (reset),
      .in_valid (v1_valid),
      .in_ready (v1_ready),
      .in_x     (v1_x),
      .in_y     (v1_side[S1_W-1:2]),
      .in_ang   ('0),
      .in_side  ({v1_ang, v1_side[1:0]}),
      .out_valid(v2_valid),
      .out_ready(v2_ready),
      .out_x    (v2_x),
      .out_y    (v2_y),
      .out_ang  (v2_ang),
      .out_side (v2_side)
   );

   // residual y of both passes is not needed
   logic unused_y;
   assign unused_y = ^{v1_y, v2_y};

   // ---- gain compensation ----
   logic              m_valid, m_ready;
   logic [63:0]       m_high;
   logic [S3_W-1:0]   m_side;

   csc_radius_mul #(.INV_GAIN(INV_GAIN), .SIDE_W(S3_W)) u_radius_mul (
      .clock    (clock),
      .reset    (reset),
      .in_valid (v2_valid),
      .in_ready (v2_ready),
      .in_mag   (v2_x),
      .in_side  ({v2_ang, v2_side}),
      .out_valid(m_valid),
      .out_ready(m_ready),
      .out_high (m_high),
      .out_side (m_side)
   );

   // ---- output register: rounding, saturation, zero-vector repair ----
   logic                    out_valid_ff;
   logic [COORD_WIDTH-1:0]  radius_ff, radius_in;
   logic signed [ANG_OUT_W-1:0] elev_ff, elev_in, azim_ff, azim_in;
   logic signed [ANG_W-1:0] el_acc, az_acc, el_rnd, az_rnd, el_sh;
   logic                    xy_zero, all_zero;
   logic [63:0]             r_rnd, r_sh;

   assign el_acc   = m_side[S3_W-1 -: ANG_W];
   assign az_acc   = m_side[ANG_W+1:2];
   assign xy_zero  = m_side[1];
   assign all_zero = m_side[0];

   assign az_rnd = az_acc + HALF_LSB;
   assign el_rnd = el_acc + HALF_LSB;
   assign el_sh  = el_rnd >>> AFRAC;
   assign r_rnd  = m_high + (64'd1 << (GUARD - 3));
   assign r_sh   = r_rnd >> (GUARD - 2);

   always_comb begin
      azim_in = xy_zero ? '0 : az_rnd[AFRAC+ANG_OUT_W-1:AFRAC];
      if (all_zero)             elev_in = '0;
      else if (el_sh > EL_LIM)  elev_in = ANG_OUT_W'(EL_LIM);
      else if (el_sh < -EL_LIM) elev_in = -ANG_OUT_W'(EL_LIM);
      else                      elev_in = el_sh[ANG_OUT_W-1:0];
      if (all_zero)                  radius_in = '0;
      else if (r_sh[63:COORD_WIDTH] != '0) radius_in = '1;
      else                           radius_in = r_sh[COORD_WIDTH-1:0];
   end

   assign m_ready = ~out_valid_ff | rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (m_ready) begin
         out_valid_ff <= m_valid;
      end
      if (m_ready && m_valid) begin
         radius_ff <= radius_in;
         elev_ff   <= elev_in;
         azim_ff   <= azim_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_radius    = radius_ff;
   assign rsp_elevation = elev_ff;
   assign rsp_azimuth   = azim_ff;

   // ---- checks ----
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_elevation <= 32'sd1073741824) && (rsp_elevation >= -32'sd1073741824))
      else $error("elevation out of range");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input stalled without a stalled result");
endmodule
`default_nettype wire

FILE: tb/sv/tb_cartesian_to_spherical_core.sv
// Self-checking testbench for the point-to-spherical CORDIC converter.
`default_nettype none
module tb_cartesian_to_spherical_core
   import csc_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITERS = 32;
   localparam int CW    = 32;
   localparam int GRD   = 58 - CW;          // guard bits below the coordinate LSB
   localparam int LAT   = 2 * ITERS + 5;    // pipeline depth

   typedef struct packed {
      logic [CW-1:0]        radius;
      logic signed [31:0]   elevation;
      logic signed [31:0]   azimuth;
   } sph_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic signed [CW-1:0] req_x_coord = '0;
   logic signed [CW-1:0] req_y_coord = '0;
   logic signed [CW-1:0] req_z_coord = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [CW-1:0]        rsp_radius;
   logic signed [31:0]   rsp_elevation;
   logic signed [31:0]   rsp_azimuth;

   cartesian_to_spherical_core #(.ITERATIONS(ITERS), .COORD_WIDTH(CW)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_x_coord(req_x_coord), .req_y_coord(req_y_coord), .req_z_coord(req_z_coord),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_radius(rsp_radius), .rsp_elevation(rsp_elevation), .rsp_azimuth(rsp_azimuth)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Predictor tables: arctangent steps and the inverse of the double gain
   logic signed [63:0] atan_step [ITERS];
   logic [63:0]        inv_gain2;
   sph_type            pending_points [$];
   int                 errors = 0;
   bit                 quiet = 1'b0;     // no idling on either side

   function automatic logic [63:0] hi64(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[127:64];
   endfunction

   // atan(2^-i)/pi by truncated Taylor terms, AFRAC bits below the binary angle
   task automatic build_tables();
      logic [63:0] acc;
      logic [63:0] q;
      int          sh;
      for (int i = 0; i < ITERS; i++) begin
         if (i == 0) begin
            atan_step[i] = 64'sd1 <<< (29 + AFRAC);
         end else begin
            acc = '0;
            for (int k = 0; k < 64; k++) begin
               sh = i * (2 * k + 1);
               if (sh >= 63) break;
               if (k % 2 == 1) acc = acc - (64'd1 << (63 - sh)) / 64'(2 * k + 1);
               else            acc = acc + (64'd1 << (63 - sh)) / 64'(2 * k + 1);
            end
            q = hi64(acc, INV_PI_Q64);
            q = (q + (64'd1 << (31 - AFRAC))) >> (32 - AFRAC);
            atan_step[i] = q;
         end
      end
      inv_gain2 = 64'd1 << 62;
      for (int i = 0; i < ITERS; i++)
         if (2 * i < 63) inv_gain2 = inv_gain2 - inv_gain2 / ((64'd1 << (2 * i)) + 64'd1);
   endtask

   task automatic rotate_to_axis(inout logic signed [63:0] vx, inout logic signed [63:0] vy,
                                 inout logic signed [63:0] ang);
      logic signed [63:0] dx, dy;
      for (int i = 0; i < ITERS; i++) begin
         dx = vy >>> i;
         dy = vx >>> i;
         if (vy >= 0) begin
            vx = vx + dx; vy = vy - dy; ang = ang + atan_step[i];
         end else begin
            vx = vx - dx; vy = vy + dy; ang = ang - atan_step[i];
         end
      end
   endtask

   task automatic predict_point(input logic signed [CW-1:0] xi, input logic signed [CW-1:0] yi,
                                input logic signed [CW-1:0] zi, output sph_type res);
      logic signed [63:0] px, py, pz, az, el, len, v;
      logic [63:0]        az_r, r;
      bit                 xy_zero, all_zero;
      px = 64'(xi) <<< GRD;
      py = 64'(yi) <<< GRD;
      pz = 64'(zi) <<< GRD;
      az = '0;
      el = '0;
      xy_zero  = (xi == 0) && (yi == 0);
      all_zero = xy_zero && (zi == 0);
      if (px < 0) begin                       // fold negative x by a half turn
         px = -px; py = -py; az = 64'sd1 <<< (31 + AFRAC);
      end
      rotate_to_axis(px, py, az);
      len = px;
      rotate_to_axis(len, pz, el);
      az_r = (az + (64'sd1 <<< (AFRAC - 1))) >> AFRAC;
      res.azimuth = xy_zero ? 32'sd0 : az_r[31:0];
      v = (el + (64'sd1 <<< (AFRAC - 1))) >>> AFRAC;
      if (v > (64'sd1 <<< 30))  v = 64'sd1 <<< 30;
      if (v < -(64'sd1 <<< 30)) v = -(64'sd1 <<< 30);
      res.elevation = all_zero ? 32'sd0 : v[31:0];
      if (len < 0) len = '0;
      r = hi64(len, inv_gain2);
      r = (r + (64'd1 << (GRD - 3))) >> (GRD - 2);
      if (r > {32'd0, {CW{1'b1}}}) r = {32'd0, {CW{1'b1}}};
      res.radius = all_zero ? '0 : r[CW-1:0];
   endtask

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      errors++;
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
   endtask

   // Sends one item; called just after a rising edge, returns just after its acceptance
   task automatic send_point(input logic signed [CW-1:0] xi, input logic signed [CW-1:0] yi,
                             input logic signed [CW-1:0] zi);
      sph_type p;
      int      gap;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 15);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_x_coord <= xi;
      req_y_coord <= yi;
      req_z_coord <= zi;
      predict_point(xi, yi, zi, p);
      do @(posedge clock); while (!req_ready);
      pending_points.push_back(p);
   endtask

   task automatic park_sender();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Response side: random stall bursts, none once quiet is set
   int stall_left = 0;
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_ready <= 1'b1;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 14);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Result checker: every accepted item against the oldest prediction
   always @(posedge clock) begin
      sph_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_points.size() == 0) begin
            report("unexpected item", {32'd0, rsp_radius}, 64'd0);
         end else begin
            want = pending_points.pop_front();
            if (rsp_radius !== want.radius)
               report("radius", 64'(rsp_radius), 64'(want.radius));
            if (rsp_elevation !== want.elevation)
               report("elevation", 64'(rsp_elevation), 64'(want.elevation));
            if (rsp_azimuth !== want.azimuth)
               report("azimuth", 64'(rsp_azimuth), 64'(want.azimuth));
         end
      end
   end

   localparam logic signed [CW-1:0] PMAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] NMIN = {1'b1, {(CW-1){1'b0}}};

   // Axes, octants, zero vector, folded negative x, saturation extremes
   task automatic test_directed();
      send_point(0, 0, 0);                  // zero vector
      send_point(0, 0, PMAX);               // straight up, no azimuth
      send_point(0, 0, -PMAX);
      send_point(0, 0, NMIN);
      send_point(1, 0, 0);
      send_point(-1, 0, 0);                 // half turn fold
      send_point(0, 1, 0);
      send_point(0, -1, 0);
      send_point(-5, -1, 3);
      send_point(-5, 1, -3);
      send_point(PMAX, PMAX, PMAX);         // large radius on the diagonal
      send_point(-PMAX, -PMAX, -PMAX);
      send_point(NMIN, NMIN, NMIN);
      send_point(PMAX, -PMAX, 0);
      send_point(-PMAX, PMAX, PMAX);
      send_point(NMIN, 0, 0);
      send_point(0, NMIN, 1);
      send_point(1, 1, PMAX);               // elevation near the pole
      send_point(-1, -1, -PMAX);
      send_point(1000, 1000, 1000);
      send_point(-7, 0, 7);
      send_point(0, 0, 1);
   endtask

   function automatic logic signed [CW-1:0] rand_coord();
      case ($urandom_range(0, 5))
         0:       return 0;
         1:       return $signed(CW'($urandom_range(0, 64))) - 32;
         2:       return $urandom_range(0, 1) ? PMAX : NMIN;
         3:       return $signed(CW'($urandom_range(0, 1 << 20))) - (1 << 19);
         default: return $urandom;
      endcase
   endfunction

   task automatic test_random(input int n);
      for (int k = 0; k < n; k++) send_point(rand_coord(), rand_coord(), rand_coord());
   endtask

   // Sender holds back until the pipeline has drained completely
   task automatic test_drain_pause();
      park_sender();
      while (pending_points.size() != 0) @(posedge clock);
      test_random(40);
   endtask

   task automatic test_full_rate();
      quiet = 1'b1;
      test_random(200);
   endtask

   initial begin
      build_tables();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(500);
      test_drain_pause();
      test_random(500);
      test_full_rate();
      park_sender();
      while (pending_points.size() != 0) @(posedge clock);
      repeat (LAT + 10) @(posedge clock);
      if (errors == 0) begin
         $display("tb_cartesian_to_spherical_core: PASS");
      end else begin
         $display("tb_cartesian_to_spherical_core: FAIL");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("tb_cartesian_to_spherical_core: FAIL");
      $finish;
   end

endmodule
`default_nettype wire

FILE: filelist.f
hdl/csc_pkg.sv
hdl/csc_vec_stage.sv
hdl/csc_vector.sv
hdl/csc_radius_mul.sv
hdl/cartesian_to_spherical_core.sv
tb/sv/tb_cartesian_to_spherical_core.sv
